// ===== hw/rtl/ctd_pkg.sv =====
// shared types and constants for the chunked transfer decoder
package ctd_pkg;

   localparam int SIZE_BITS = 32;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_SEMI  = 8'h3b;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      PH_SIZE   = 3'd0,
      PH_CR     = 3'd1,
      PH_DATA   = 3'd2,
      PH_TRAIL1 = 3'd3,
      PH_TRAIL2 = 3'd4,
      PH_DONE   = 3'd5,
      PH_ERROR  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_END   = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   // byte classification
   typedef struct packed {
      logic       is_cr;
      logic       is_lf;
      logic       is_ext;
      logic       is_hex;
      logic [3:0] nibble;
   } class_type;

   // result of one decode step
   typedef struct packed {
      logic       emit;
      logic [7:0] payload;
      status_type status;
   } result_type;

endpackage

// ===== hw/rtl/ctd_class.sv =====
// byte classifier: framing characters and hex digit value
module ctd_class
   import ctd_pkg::*;
(
   input  logic [7:0] body_byte,
   output class_type  cls
);

   logic is_digit;
   logic is_lower;
   logic is_upper;

   always_comb begin
      is_digit = (body_byte >= 8'h30) && (body_byte <= 8'h39);
      is_lower = (body_byte >= 8'h61) && (body_byte <= 8'h66);
      is_upper = (body_byte >= 8'h41) && (body_byte <= 8'h46);
      cls.is_cr  = (body_byte == CHAR_CR);
      cls.is_lf  = (body_byte == CHAR_LF);
      cls.is_ext = (body_byte == CHAR_SEMI) || (body_byte == CHAR_SPACE) ||
                   (body_byte == CHAR_TAB);
      cls.is_hex = is_digit || is_lower || is_upper;
      // letters a-f / A-F have low nibble 1..6
      cls.nibble = is_digit ? body_byte[3:0] : (body_byte[3:0] + 4'd9);
   end

endmodule

// ===== hw/rtl/ctd_core.sv =====
// framing state and single-step decode logic
module ctd_core
   import ctd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] body_byte,
   output result_type res,
   output phase_type  phase
);

   class_type            cls;
   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [SIZE_BITS-1:0] bytes_dec;
   logic                 digit_seen_ff, digit_seen_in;
   logic                 in_ext_ff, in_ext_in;

   ctd_class u_class (
      .body_byte (body_byte),
      .cls       (cls)
   );

   assign phase = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         bytes_left_ff <= '0;
         digit_seen_ff <= 1'b0;
         in_ext_ff     <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         digit_seen_ff <= digit_seen_in;
         in_ext_ff     <= in_ext_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      digit_seen_in = digit_seen_ff;
      in_ext_in     = in_ext_ff;
      bytes_dec     = bytes_left_ff - SIZE_BITS'(1);
      res.emit      = 1'b0;
      res.payload   = 8'h00;
      res.status    = ST_DATA;
      unique case (phase_ff)
         PH_SIZE: begin
            if (cls.is_cr) begin
               phase_in = PH_CR;
            end else if (in_ext_ff) begin
               phase_in = PH_SIZE;
            end else if (cls.is_ext) begin
               in_ext_in = 1'b1;
            end else if (!cls.is_hex || (bytes_left_ff[SIZE_BITS-1 -: 4] != 4'h0)) begin
               phase_in   = PH_ERROR;
               res.emit   = 1'b1;
               res.status = ST_ERROR;
            end else begin
               bytes_left_in = {bytes_left_ff[SIZE_BITS-5:0], cls.nibble};
               digit_seen_in = 1'b1;
            end
         end
         PH_CR: begin
            if (cls.is_lf) begin
               if (!digit_seen_ff) begin
                  phase_in   = PH_ERROR;
                  res.emit   = 1'b1;
                  res.status = ST_ERROR;
               end else if (bytes_left_ff == '0) begin
                  phase_in   = PH_DONE;
                  res.emit   = 1'b1;
                  res.status = ST_END;
               end else begin
                  phase_in = PH_DATA;
               end
            end else if (!in_ext_ff) begin
               phase_in   = PH_ERROR;
               res.emit   = 1'b1;
               res.status = ST_ERROR;
            end else begin
               // lone cr inside an extension is skipped
               phase_in = cls.is_cr ? PH_CR : PH_SIZE;
            end
         end
         PH_DATA: begin
            bytes_left_in = bytes_dec;
            if (bytes_dec == '0) begin
               phase_in = PH_TRAIL1;
            end
            res.emit    = 1'b1;
            res.payload = body_byte;
            res.status  = ST_DATA;
         end
         PH_TRAIL1: begin
            phase_in = PH_TRAIL2;
         end
         PH_TRAIL2: begin
            phase_in      = PH_SIZE;
            bytes_left_in = '0;
            digit_seen_in = 1'b0;
            in_ext_in     = 1'b0;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

endmodule

// ===== hw/rtl/chunked_transfer_decoder_unit.sv =====
// top level of the chunked transfer decoder: input register, decode step, result register
//
// usage
//   req channel: one body byte per request on req_body_byte, taken when
//   req_valid and req_ready are both high. bytes are the raw chunked body
//   that follows the response headers.
//   rsp channel: zero or one result per request. rsp_status is data (0) with
//   the payload byte on rsp_payload_byte, end of body (1) or framing error (2).
//   a request is held in the input register after its acceptance edge; once
//   the result register is free, the decode step commits and its result, if
//   any, is registered in the result register and is then valid on rsp.
//   throughput: one request per cycle while rsp_ready keeps the result
//   register free; the decode step between the two registers is combinational.
//   reset: clears the input and result valids and returns the parser to the
//   start of a size line with a zero size.
//   stall: while rsp_ready is low and a result is held, the input register
//   keeps its byte and req_ready drops once it is full; nothing is dropped.
//   after an end or error result all later bytes are consumed silently.
module chunked_transfer_decoder_unit
   import ctd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_body_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic [1:0] rsp_status
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_payload_ff;
   status_type out_status_ff;

   logic       out_free;
   logic       step;
   logic       req_take;
   result_type res;
   phase_type  phase;

   // result register can take a new entry when empty or being drained
   assign out_free  = !out_valid_ff || rsp_ready;
   // decode the buffered byte and commit its state update
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;
   assign req_take  = req_valid && req_ready;

   ctd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .body_byte (in_byte_ff),
      .res       (res),
      .phase     (phase)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = res.emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_body_byte;
      end
      if (step && res.emit) begin
         out_payload_ff <= res.payload;
         out_status_ff  <= res.status;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_payload_ff;
   assign rsp_status       = out_status_ff;

   // end of body is terminal
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase == PH_DONE) |=> (phase == PH_DONE))
      else $error("parser left the done phase");

   // an error result is only produced together with the error phase
   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_ERROR)) |-> (phase == PH_ERROR))
      else $error("error result without error phase");

   // a committed step whose result is a data byte came from the data phase
   a_data_from_data: assert property (@(posedge clock) disable iff (reset)
      (step && res.emit && (res.status == ST_DATA)) |-> (phase == PH_DATA))
      else $error("data result outside the data phase");

endmodule
